/* sv/vde_pkg.sv */
// Shared types, constants and helper functions of the voxel distance erosion block.
package vde_pkg;

  localparam int unsigned SIDE_DEF  = 32;
  localparam int unsigned FRAC_DEF  = 8;
  localparam int unsigned DIST_W    = 16;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned EXT_W     = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2
  } vde_action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_EROSION   = 3'd1,
    CFG_EXTENT_X  = 3'd2,
    CFG_EXTENT_Y  = 3'd3,
    CFG_EXTENT_Z  = 3'd4
  } vde_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_NBR,
    ST_FIN,
    ST_WR
  } vde_state_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic             empty_in;
  } vde_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_out;
    logic              empty_out;
  } vde_out_t;

  typedef struct packed {
    logic vox_write;
    logic vox_read;
    logic init_begin;
    logic init_read;
    logic init_write;
    logic pass_begin;
    logic nbr_issue;
    logic cell_write;
    logic set_done;
  } vde_cmd_t;

  typedef struct packed {
    logic last_cell;
    logic last_nbr;
    logic changed;
  } vde_sts_t;

  // Rounded integer square root, evaluated at elaboration for the step weights.
  function automatic int unsigned isqrt_round(int unsigned n);
    int unsigned s;
    int unsigned t;
    s = 0;
    for (int b = 15; b >= 0; b--) begin
      t = s | (32'd1 << b);
      if (t * t <= n) s = t;
    end
    if (n - s * s > s) s = s + 1;
    return s;
  endfunction

endpackage

/* sv/vde_ctrl.sv */
// Sequencer for voxel access, grid initialization and relaxation passes.
module vde_ctrl import vde_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [1:0]  action_i,
  input  vde_sts_t    sts_i,
  output logic        busy,
  output vde_cmd_t    cmd_o
);

  vde_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          case (vde_action_e'(action_i))
            ACT_WRITE: cmd_o.vox_write = 1'b1;
            ACT_READ:  cmd_o.vox_read  = 1'b1;
            ACT_RUN: begin
              cmd_o.init_begin = 1'b1;
              state_d = ST_INIT_RD;
            end
            default: ;
          endcase
        end
      end
      ST_INIT_RD: begin
        cmd_o.init_read = 1'b1;
        state_d = ST_INIT_WR;
      end
      ST_INIT_WR: begin
        cmd_o.init_write = 1'b1;
        if (sts_i.last_cell) begin
          cmd_o.pass_begin = 1'b1;
          state_d = ST_NBR;
        end else begin
          state_d = ST_INIT_RD;
        end
      end
      ST_NBR: begin
        cmd_o.nbr_issue = 1'b1;
        if (sts_i.last_nbr) state_d = ST_FIN;
      end
      ST_FIN: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        cmd_o.cell_write = 1'b1;
        if (sts_i.last_cell) begin
          if (sts_i.changed) begin
            cmd_o.pass_begin = 1'b1;
            state_d = ST_NBR;
          end else begin
            cmd_o.set_done = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_NBR;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* sv/vde_datapath.sv */
// Voxel memories, configuration registers, scan counters and relaxation arithmetic.
module vde_datapath import vde_pkg::*; #(
  parameter int unsigned SIDE      = SIDE_DEF,
  parameter int unsigned FRAC_BITS = FRAC_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [DIST_W-1:0]     cfg_data_i,
  input  vde_in_t               item_i,
  input  vde_cmd_t              cmd_i,
  output vde_sts_t              sts_o,
  output vde_out_t              result_o,
  output logic                  result_valid_o
);

  localparam int unsigned CW    = $clog2(SIDE);
  localparam int unsigned EW    = $clog2(SIDE + 1);
  localparam int unsigned SW    = EW + 1;
  localparam int unsigned CELLS = SIDE * SIDE * SIDE;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam logic [DIST_W-1:0] W1 = DIST_W'(32'd1 << FRAC_BITS);
  localparam logic [DIST_W-1:0] W2 = DIST_W'(isqrt_round(32'd2 << (2 * FRAC_BITS)));
  localparam logic [DIST_W-1:0] W3 = DIST_W'(isqrt_round(32'd3 << (2 * FRAC_BITS)));

  function automatic logic [AW-1:0] cidx(logic [CW-1:0] x, logic [CW-1:0] y,
                                         logic [CW-1:0] z);
    return AW'(x) + AW'(SIDE) * AW'(y) + AW'(SIDE * SIDE) * AW'(z);
  endfunction

  function automatic logic [EW-1:0] clamp_ext(logic [EXT_W-1:0] e);
    if (e == '0) return EW'(1);
    if (32'(e) > SIDE) return EW'(SIDE);
    return EW'(e);
  endfunction

  // Configuration
  logic [DIST_W-1:0] thr_q;
  logic              ee_q;
  logic [EXT_W-1:0]  ext_x_q, ext_y_q, ext_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      ee_q    <= 1'b1;
      ext_x_q <= EXT_W'(32);
      ext_y_q <= EXT_W'(32);
      ext_z_q <= EXT_W'(32);
    end else if (cfg_we_i) begin
      case (vde_cfg_e'(cfg_idx_i))
        CFG_THRESHOLD: thr_q   <= cfg_data_i;
        CFG_EROSION:   ee_q    <= cfg_data_i[0];
        CFG_EXTENT_X:  ext_x_q <= cfg_data_i[EXT_W-1:0];
        CFG_EXTENT_Y:  ext_y_q <= cfg_data_i[EXT_W-1:0];
        CFG_EXTENT_Z:  ext_z_q <= cfg_data_i[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [EW-1:0] ex_c, ey_c, ez_c;
  assign ex_c = clamp_ext(ext_x_q);
  assign ey_c = clamp_ext(ext_y_q);
  assign ez_c = clamp_ext(ext_z_q);

  // Scan counters
  logic          init_q, dir_q;
  logic [CW-1:0] cx_q, cy_q, cz_q;
  logic [EW-1:0] lx, ly, lz;
  logic [CW-1:0] mx, my, mz, px, py, pz;
  logic          nd, last_cell;

  assign lx = init_q ? EW'(SIDE) : ex_c;
  assign ly = init_q ? EW'(SIDE) : ey_c;
  assign lz = init_q ? EW'(SIDE) : ez_c;
  assign mx = CW'(lx - EW'(1));
  assign my = CW'(ly - EW'(1));
  assign mz = CW'(lz - EW'(1));
  assign px = CW'(ex_c - EW'(1));
  assign py = CW'(ey_c - EW'(1));
  assign pz = CW'(ez_c - EW'(1));
  assign nd = init_q ? 1'b0 : ~dir_q;
  assign last_cell = dir_q ? (cx_q == '0 && cy_q == '0 && cz_q == '0)
                           : (cx_q == mx && cy_q == my && cz_q == mz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= 1'b0;
      dir_q  <= 1'b0;
      cx_q   <= '0;
      cy_q   <= '0;
      cz_q   <= '0;
    end else if (cmd_i.init_begin) begin
      init_q <= 1'b1;
      dir_q  <= 1'b0;
      cx_q   <= '0;
      cy_q   <= '0;
      cz_q   <= '0;
    end else if (cmd_i.pass_begin) begin
      init_q <= 1'b0;
      dir_q  <= nd;
      cx_q   <= nd ? px : '0;
      cy_q   <= nd ? py : '0;
      cz_q   <= nd ? pz : '0;
    end else if (cmd_i.init_write || cmd_i.cell_write) begin
      if (!dir_q) begin
        if (cx_q != mx) begin
          cx_q <= cx_q + CW'(1);
        end else begin
          cx_q <= '0;
          if (cy_q != my) begin
            cy_q <= cy_q + CW'(1);
          end else begin
            cy_q <= '0;
            cz_q <= cz_q + CW'(1);
          end
        end
      end else begin
        if (cx_q != '0) begin
          cx_q <= cx_q - CW'(1);
        end else begin
          cx_q <= mx;
          if (cy_q != '0) begin
            cy_q <= cy_q - CW'(1);
          end else begin
            cy_q <= my;
            cz_q <= cz_q - CW'(1);
          end
        end
      end
    end
  end

  // Neighbor counters, one offset per axis, x fastest
  logic [1:0] kx_q, ky_q, kz_q;
  logic       last_nbr;
  assign last_nbr = (kx_q == 2'd2) && (ky_q == 2'd2) && (kz_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kx_q <= '0;
      ky_q <= '0;
      kz_q <= '0;
    end else if (cmd_i.nbr_issue) begin
      if (kx_q != 2'd2) begin
        kx_q <= kx_q + 2'd1;
      end else begin
        kx_q <= '0;
        if (ky_q != 2'd2) begin
          ky_q <= ky_q + 2'd1;
        end else begin
          ky_q <= '0;
          kz_q <= (kz_q != 2'd2) ? kz_q + 2'd1 : 2'd0;
        end
      end
    end
  end

  logic [SW-1:0] sx, sy, sz;
  logic          nvalid;
  logic [CW-1:0] nx, ny, nz;
  logic [1:0]    steps;

  assign sx = SW'(cx_q) + SW'(kx_q);
  assign sy = SW'(cy_q) + SW'(ky_q);
  assign sz = SW'(cz_q) + SW'(kz_q);
  assign nvalid = (sx != '0) && (sx <= SW'(lx)) && (sy != '0) && (sy <= SW'(ly)) &&
                  (sz != '0) && (sz <= SW'(lz));
  assign nx = CW'(sx - SW'(1));
  assign ny = CW'(sy - SW'(1));
  assign nz = CW'(sz - SW'(1));
  assign steps = 2'(kx_q != 2'd1) + 2'(ky_q != 2'd1) + 2'(kz_q != 2'd1);

  // Addresses
  logic [AW-1:0] scan_idx, nbr_idx, pos_idx, rd_addr;
  logic          pos_inside;

  assign scan_idx = cidx(cx_q, cy_q, cz_q);
  assign nbr_idx  = cidx(nx, ny, nz);
  assign pos_idx  = cidx(CW'(item_i.pos_x), CW'(item_i.pos_y), CW'(item_i.pos_z));
  assign pos_inside = (32'(item_i.pos_x) < SIDE) && (32'(item_i.pos_y) < SIDE) &&
                      (32'(item_i.pos_z) < SIDE);
  assign rd_addr = cmd_i.nbr_issue ? nbr_idx : (cmd_i.init_read ? scan_idx : pos_idx);

  // Memories
  logic              occ_mem [CELLS];
  logic [DIST_W-1:0] dist_mem [CELLS];
  logic              occ_rd_q;
  logic [DIST_W-1:0] dist_rd_q;
  logic              occ_we, dist_we;
  logic [DIST_W-1:0] dist_wd;

  always_ff @(posedge clk_i) begin
    occ_rd_q  <= occ_mem[rd_addr];
    dist_rd_q <= dist_mem[rd_addr];
    if (occ_we)  occ_mem[pos_idx]   <= item_i.empty_in;
    if (dist_we) dist_mem[scan_idx] <= dist_wd;
  end

  // Relaxation
  logic              v1_q;
  logic [1:0]        st1_q;
  logic [DIST_W-1:0] acc_q, own_q, wsel;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] cand;
  logic              improve, changed_q, in_ext;

  always_comb begin
    case (st1_q)
      2'd1:    wsel = W1;
      2'd2:    wsel = W2;
      2'd3:    wsel = W3;
      default: wsel = '0;
    endcase
  end

  assign sum  = {1'b0, dist_rd_q} + {1'b0, wsel};
  assign cand = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  assign improve = acc_q < own_q;
  assign in_ext = (EW'(cx_q) < ex_c) && (EW'(cy_q) < ey_c) && (EW'(cz_q) < ez_c);

  assign occ_we  = cmd_i.vox_write && pos_inside;
  assign dist_we = cmd_i.init_write || (cmd_i.cell_write && improve);
  assign dist_wd = cmd_i.init_write ? ((occ_rd_q && in_ext) ? '0 : DIST_MAX) : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      changed_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.nbr_issue && nvalid;
      if (cmd_i.pass_begin) begin
        changed_q <= 1'b0;
      end else if (cmd_i.cell_write && improve) begin
        changed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st1_q <= steps;
    if (cmd_i.pass_begin || cmd_i.cell_write) begin
      acc_q <= DIST_MAX;
    end else if (v1_q && cand < acc_q) begin
      acc_q <= cand;
    end
    if (v1_q && st1_q == 2'd0) own_q <= dist_rd_q;
  end

  assign sts_o.last_cell = last_cell;
  assign sts_o.last_nbr  = last_nbr;
  assign sts_o.changed   = changed_q || (cmd_i.cell_write && improve);

  // Voxel reads
  logic computed_q, pend_q, rin_q, rcomp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      computed_q <= 1'b0;
      pend_q     <= 1'b0;
    end else begin
      pend_q <= cmd_i.vox_read;
      if (occ_we) begin
        computed_q <= 1'b0;
      end else if (cmd_i.set_done) begin
        computed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.vox_read) begin
      rin_q   <= pos_inside;
      rcomp_q <= computed_q;
    end
  end

  logic [DIST_W-1:0] rd_dist;
  assign rd_dist = (rin_q && rcomp_q) ? dist_rd_q : DIST_MAX;
  assign result_valid_o        = pend_q;
  assign result_o.distance_out = rd_dist;
  assign result_o.empty_out    = rin_q && (occ_rd_q || (ee_q && rcomp_q && rd_dist < thr_q));

endmodule

/* sv/voxel_distance_erosion_core.sv */
// Top level of the voxel distance erosion block: controller plus datapath.
//
// Usage: present an item on item_i with start high while busy is low.
//   write (action 0): stores the empty bit of one voxel; no result.
//   read  (action 2): the result appears on result_o in the next cycle, with
//     result_valid_o high for exactly that cycle. Reads and writes may be
//     issued every cycle.
//   run   (action 1): rebuilds the distance grid; busy stays high until done.
//     It first sweeps all SIDE^3 voxels, each through a read and a write state,
//     then runs relaxation passes over the active extent, alternating raster
//     direction; for each voxel the 27 neighbor positions (itself included) are
//     read through the single distance memory read port, followed by a finish
//     state and a write-back state. Passes repeat until one changes nothing.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while idle.
// Reset clears the control state and restores the register defaults; voxel
// memories are not cleared. The receiver cannot stall: each result is taken
// in its strobe cycle.
module voxel_distance_erosion_core import vde_pkg::*; #(
  parameter int unsigned SIDE      = SIDE_DEF,
  parameter int unsigned FRAC_BITS = FRAC_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [DIST_W-1:0]    cfg_data_i,
  input  logic                 start,
  output logic                 busy,
  input  vde_in_t              item_i,
  output vde_out_t             result_o,
  output logic                 result_valid_o
);

  vde_cmd_t cmd;
  vde_sts_t sts;

  // Sequence runs and decode voxel accesses
  vde_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (item_i.action),
    .sts_i    (sts),
    .busy     (busy),
    .cmd_o    (cmd)
  );

  // Hold memories, registers and the relaxation arithmetic
  vde_datapath #(
    .SIDE      (SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

/* bench/tb.sv */
// Testbench for voxel_distance_erosion_core: directed and random items checked against a predictor.
module tb;
  import vde_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GRID   = 32;
  localparam int unsigned CELLS  = GRID * GRID * GRID;
  // Step weights in Q8.8: face, edge, corner.
  localparam int unsigned W_FACE = 256;
  localparam int unsigned W_EDGE = 362;
  localparam int unsigned W_CORN = 443;
  // Covers the full-grid sweep plus the passes over the largest extent we ever run.
  localparam int unsigned STALL_LIMIT = 400000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DIST_W-1:0]    cfg_data_i;
  logic                 start;
  logic                 busy;
  vde_in_t              item_i;
  vde_out_t             result_o;
  logic                 result_valid_o;

  voxel_distance_erosion_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  // Predictor state: loaded empty bits, computed distances, register copies.
  bit                occ_bits  [CELLS];
  logic [DIST_W-1:0] dist_grid [CELLS];
  bit                queued    [CELLS];
  bit                grid_computed;
  logic [15:0]       thr_reg;
  bit                erode_reg;
  logic [5:0]        ext_x, ext_y, ext_z;

  vde_out_t    pending_reads[$];
  int unsigned error_count;
  int unsigned stall_cycles;
  int unsigned gap_pct;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned cidx(int unsigned x, int unsigned y, int unsigned z);
    return x + GRID * (y + GRID * z);
  endfunction

  function automatic int unsigned clamp_ext(logic [5:0] e);
    if (e == 0) return 1;
    if (32'(e) > GRID) return GRID;
    return 32'(e);
  endfunction

  // Relax distances from every empty cell in the extent over all 26 neighbors.
  function automatic void predict_transform();
    int unsigned ex, ey, ez, i, cx, cy, cz, steps, v, n;
    int          nx, ny, nz;
    int unsigned work[$];
    ex = clamp_ext(ext_x);
    ey = clamp_ext(ext_y);
    ez = clamp_ext(ext_z);
    for (int k = 0; k < CELLS; k++) begin
      dist_grid[k] = DIST_MAX;
      queued[k] = 1'b0;
    end
    for (int z = 0; z < ez; z++)
      for (int y = 0; y < ey; y++)
        for (int x = 0; x < ex; x++) begin
          i = cidx(x, y, z);
          if (occ_bits[i]) begin
            dist_grid[i] = '0;
            queued[i] = 1'b1;
            work.push_back(i);
          end
        end
    while (work.size() > 0) begin
      i = work.pop_front();
      queued[i] = 1'b0;
      cx = i % GRID;
      cy = (i / GRID) % GRID;
      cz = i / (GRID * GRID);
      for (int oz = -1; oz <= 1; oz++)
        for (int oy = -1; oy <= 1; oy++)
          for (int ox = -1; ox <= 1; ox++) begin
            nx = cx + ox;
            ny = cy + oy;
            nz = cz + oz;
            steps = 32'(ox != 0) + 32'(oy != 0) + 32'(oz != 0);
            if (steps == 0 || nx < 0 || ny < 0 || nz < 0) continue;
            if (nx >= ex || ny >= ey || nz >= ez) continue;
            v = 32'(dist_grid[i]) + (steps == 1 ? W_FACE : steps == 2 ? W_EDGE : W_CORN);
            if (v > 32'(DIST_MAX)) v = 32'(DIST_MAX);
            n = cidx(nx, ny, nz);
            if (v < 32'(dist_grid[n])) begin
              dist_grid[n] = DIST_W'(v);
              if (!queued[n]) begin
                queued[n] = 1'b1;
                work.push_back(n);
              end
            end
          end
    end
    grid_computed = 1'b1;
  endfunction

  // Apply one accepted item to the predictor; reads queue an expected result.
  function automatic void predict_item(vde_in_t it);
    int unsigned i;
    vde_out_t    exp_r;
    i = cidx(32'(it.pos_x), 32'(it.pos_y), 32'(it.pos_z));
    case (it.action)
      ACT_WRITE: begin
        occ_bits[i] = it.empty_in;
        grid_computed = 1'b0;
      end
      ACT_RUN: predict_transform();
      ACT_READ: begin
        exp_r.distance_out = grid_computed ? dist_grid[i] : DIST_MAX;
        exp_r.empty_out = occ_bits[i] |
                          (erode_reg & grid_computed & (exp_r.distance_out < thr_reg));
        pending_reads.push_back(exp_r);
      end
      default: ;
    endcase
  endfunction

  // Check results, track register writes and predict accepted items at each edge.
  always @(posedge clk_i) begin
    vde_out_t exp_r;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (pending_reads.size() == 0) begin
          $display("%0t: unexpected result distance=%0d empty=%0b", $time,
                   result_o.distance_out, result_o.empty_out);
          error_count++;
        end else begin
          exp_r = pending_reads.pop_front();
          if (result_o.distance_out !== exp_r.distance_out) begin
            $display("%0t: distance expected %0d actual %0d", $time,
                     exp_r.distance_out, result_o.distance_out);
            error_count++;
          end
          if (result_o.empty_out !== exp_r.empty_out) begin
            $display("%0t: empty bit expected %0b actual %0b", $time,
                     exp_r.empty_out, result_o.empty_out);
            error_count++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_THRESHOLD: thr_reg   = cfg_data_i;
          CFG_EROSION:   erode_reg = cfg_data_i[0];
          CFG_EXTENT_X:  ext_x     = cfg_data_i[5:0];
          CFG_EXTENT_Y:  ext_y     = cfg_data_i[5:0];
          CFG_EXTENT_Z:  ext_z     = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (start && !busy) predict_item(item_i);
      // Watchdog: any accepted item, result or write restarts the count.
      if ((start && !busy) || result_valid_o || cfg_we_i) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic vde_in_t mk_item(logic [1:0] act, int unsigned x, int unsigned y,
                                      int unsigned z, bit e);
    vde_in_t it;
    it.action = act;
    it.pos_x = POS_W'(x);
    it.pos_y = POS_W'(y);
    it.pos_z = POS_W'(z);
    it.empty_in = e;
    return it;
  endfunction

  // Hold the item until accepted, then maybe drop start and idle the sender.
  task automatic send_item(vde_in_t it);
    @(negedge clk_i);
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
      item_i <= vde_in_t'($bits(vde_in_t)'($urandom));
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
  endtask

  task automatic send_op(logic [1:0] act, int unsigned x, int unsigned y, int unsigned z,
                         bit e);
    send_item(mk_item(act, x, y, z, e));
  endtask

  // Drop start and drain: no busy run, no result still owed, then a short pause.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (busy || pending_reads.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(vde_cfg_e idx, logic [DIST_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_extent(logic [5:0] x, logic [5:0] y, logic [5:0] z);
    write_reg(CFG_EXTENT_X, DIST_W'(x));
    write_reg(CFG_EXTENT_Y, DIST_W'(y));
    write_reg(CFG_EXTENT_Z, DIST_W'(z));
  endtask

  // Pick a cell that has been loaded: the 4x4x4 corner cube or one of the axis lines.
  task automatic pick_cell(output int unsigned x, output int unsigned y,
                           output int unsigned z);
    int unsigned c;
    x = 0; y = 0; z = 0;
    if ($urandom_range(1)) begin
      x = $urandom_range(3); y = $urandom_range(3); z = $urandom_range(3);
    end else begin
      c = $urandom_range(31);
      case ($urandom_range(2))
        0: x = c;
        1: y = c;
        default: z = c;
      endcase
    end
  endtask

  // Load every cell that any read or run will touch: occupied but for the origin and (31,0,0).
  task automatic test_load_grid();
    for (int z = 0; z < 4; z++)
      for (int y = 0; y < 4; y++)
        for (int x = 0; x < 4; x++)
          send_op(ACT_WRITE, x, y, z, (x + y + z) == 0);
    for (int c = 4; c < 32; c++) begin
      send_op(ACT_WRITE, c, 0, 0, c == 31);
      send_op(ACT_WRITE, 0, c, 0, 1'b0);
      send_op(ACT_WRITE, 0, 0, c, 1'b0);
    end
  endtask

  // Reads before any run: unreached distance and the loaded bit.
  task automatic test_reads_before_run();
    send_op(ACT_READ, 0, 0, 0, 1'b0);
    send_op(ACT_READ, 3, 3, 3, 1'b1);
    send_op(ACT_READ, 31, 0, 0, 1'b0);
    send_op(ACT_READ, 0, 31, 0, 1'b0);
    send_op(ACT_READ, 0, 0, 31, 1'b0);
  endtask

  // Extents of zero act as one; cells outside stay unreached.
  task automatic test_zero_extent();
    drain();
    set_extent(6'd0, 6'd0, 6'd0);
    write_reg(CFG_THRESHOLD, 16'hFFFF);
    write_reg(CFG_EROSION, 16'd1);
    send_op(ACT_RUN, 0, 0, 0, 1'b0);
    send_op(ACT_READ, 0, 0, 0, 1'b0);
    send_op(ACT_READ, 1, 0, 0, 1'b0);
  endtask

  // An extent above the grid acts as the full side: a 32-cell line with both ends empty.
  task automatic test_long_line();
    drain();
    set_extent(6'd63, 6'd1, 6'd1);
    write_reg(CFG_THRESHOLD, 16'd300);
    send_op(ACT_RUN, 0, 0, 0, 1'b0);
    send_op(ACT_READ, 1, 0, 0, 1'b0);
    send_op(ACT_READ, 16, 0, 0, 1'b0);
    send_op(ACT_READ, 30, 0, 0, 1'b0);
    send_op(ACT_READ, 0, 1, 0, 1'b0);
  endtask

  // Cube run with erosion off, then on without rerunning.
  task automatic test_cube_erosion();
    drain();
    set_extent(6'd4, 6'd4, 6'd4);
    write_reg(CFG_EROSION, 16'd0);
    write_reg(CFG_THRESHOLD, 16'd1000);
    send_op(ACT_RUN, 0, 0, 0, 1'b0);
    send_op(ACT_READ, 3, 3, 3, 1'b0);
    send_op(ACT_READ, 1, 1, 1, 1'b0);
    drain();
    write_reg(CFG_EROSION, 16'd1);
    send_op(ACT_READ, 1, 1, 1, 1'b0);
    send_op(ACT_READ, 3, 3, 3, 1'b0);
  endtask

  // No empty cell in the extent: everything unreached. Unused action is dropped.
  task automatic test_no_empty_cell();
    send_op(ACT_WRITE, 0, 0, 0, 1'b0);
    send_op(ACT_RUN, 0, 0, 0, 1'b0);
    send_op(ACT_READ, 2, 2, 2, 1'b0);
    send_op(ACT_UNUSED, 31, 31, 31, 1'b1);
    send_op(ACT_WRITE, 0, 0, 0, 1'b1);
    send_op(ACT_READ, 0, 0, 0, 1'b0);
  endtask

  // One round: random registers, random content, a run, then mostly reads.
  task automatic random_round();
    int unsigned x, y, z, r;
    drain();
    write_reg(CFG_THRESHOLD,
              DIST_W'($urandom_range(1) ? $urandom_range(1200) : $urandom_range(65535)));
    write_reg(CFG_EROSION, DIST_W'($urandom_range(3) != 0));
    r = $urandom_range(3);
    if (r == 0) set_extent(6'd32, 6'd1, 6'd1);
    else if (r == 1) set_extent(6'($urandom_range(1)), 6'(6'd40 + $urandom_range(23)), 6'd0);
    else if (r == 2) set_extent(6'd1, 6'd0, 6'(6'd32 + $urandom_range(31)));
    else set_extent(6'($urandom_range(4)), 6'($urandom_range(4)), 6'($urandom_range(4)));
    for (int k = 0; k < 20; k++) begin
      pick_cell(x, y, z);
      send_op(ACT_WRITE, x, y, z, $urandom_range(5) == 0);
    end
    for (int k = 0; k < 2; k++) begin
      pick_cell(x, y, z);
      send_op(ACT_READ, x, y, z, 1'($urandom_range(1)));
    end
    send_op(ACT_RUN, $urandom_range(31), $urandom_range(31), $urandom_range(31),
            1'($urandom_range(1)));
    for (int k = 0; k < 97; k++) begin
      pick_cell(x, y, z);
      r = $urandom_range(99);
      if (r < 90) send_op(ACT_READ, x, y, z, 1'($urandom_range(1)));
      else if (r < 96) send_op(ACT_WRITE, x, y, z, 1'($urandom_range(1)));
      else send_op(ACT_UNUSED, $urandom_range(31), $urandom_range(31), $urandom_range(31),
                   1'($urandom_range(1)));
    end
  endtask

  task automatic test_random();
    int unsigned pct [3] = '{21, 58, 0};
    for (int m = 0; m < 3; m++) begin
      gap_pct = pct[m];
      repeat (3) random_round();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_THRESHOLD;
    cfg_data_i = '0;
    start = 1'b0;
    item_i = '0;
    error_count = 0;
    stall_cycles = 0;
    gap_pct = 21;
    grid_computed = 1'b0;
    thr_reg = '0;
    erode_reg = 1'b1;
    ext_x = 6'd32;
    ext_y = 6'd32;
    ext_z = 6'd32;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_load_grid();
    test_reads_before_run();
    test_zero_extent();
    test_long_line();
    test_cube_erosion();
    test_no_empty_cell();
    test_random();

    drain();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
